[rtl/core/message_frame_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Message frame decoder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FRAME_DECODER_DEFINES_SVH
`define MESSAGE_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfd checker: same-cycle property failed");

// Next-cycle implication, disabled during reset
`define MFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfd checker: next-cycle property failed");

`endif

[rtl/core/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// Message frame decoder package
// Types and constants shared by the decoder stages.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

    localparam int HEADER_BYTES = 13;
    localparam logic [3:0] HEADER_LAST_COUNT = 4'(HEADER_BYTES - 1);
    localparam logic [3:0] TYPE_COUNT        = 4'd0;
    localparam logic [3:0] STAMP_LAST_COUNT  = 4'd8;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SKIP    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic        status;
        logic [7:0]  message_type;
        logic [63:0] timestamp;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        end_of_message;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/mfd_in_if.sv]
// ----------------------------------------------------------------------------
// Byte channel interface
// Valid/ready channel carrying one buffer byte and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfd_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink (input valid, input data_byte, input buffer_end, output ready);

endinterface

`default_nettype wire

[rtl/core/mfd_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one decoded header or payload result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfd_out_if;

    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        status;
    logic [7:0]  message_type;
    logic [63:0] timestamp;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        end_of_message;

    modport source (
        output valid, output result_kind, output status, output message_type,
        output timestamp, output payload_length, output payload_byte,
        output end_of_message, input ready
    );
    modport sink (
        input valid, input result_kind, input status, input message_type,
        input timestamp, input payload_length, input payload_byte,
        input end_of_message, output ready
    );

endinterface

`default_nettype wire

[rtl/core/mfd_in_stage.sv]
// ----------------------------------------------------------------------------
// Message frame decoder input stage
// Registers one incoming byte transaction ahead of the frame logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_in_stage
    import mfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mfd_in_if.sink    byte_in,
    output item_t     item,
    output logic      item_valid,
    input  wire logic item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign byte_in.ready = !valid_reg || item_take;
    assign load          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte  <= byte_in.data_byte;
            item_reg.buffer_end <= byte_in.buffer_end;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

[rtl/core/mfd_frame_fsm.sv]
// ----------------------------------------------------------------------------
// Message frame decoder frame state machine
// Tracks header, payload and skip phases and forms a header result and one result per payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_frame_fsm
    import mfd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    output logic       res_valid,
    output result_t    result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic [63:0] stamp_reg;
    logic [63:0] stamp_next;
    logic [31:0] length_reg;
    logic [31:0] length_next;
    logic [31:0] left_reg;
    logic [31:0] left_next;
    logic [31:0] left_dec;

    assign left_dec = left_reg - 32'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        type_next   = type_reg;
        stamp_next  = stamp_reg;
        length_next = length_reg;
        left_next   = left_reg;
        res_valid   = 1'b0;
        result      = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (count_reg == TYPE_COUNT)
                    begin
                        type_next = item.data_byte;
                    end
                    else if (count_reg <= STAMP_LAST_COUNT)
                    begin
                        stamp_next = {stamp_reg[55:0], item.data_byte};
                    end
                    else
                    begin
                        length_next = {length_reg[23:0], item.data_byte};
                    end

                    if (count_reg >= HEADER_LAST_COUNT)
                    begin
                        res_valid             = 1'b1;
                        result.result_kind    = KIND_HEADER;
                        result.message_type   = type_next;
                        result.timestamp      = stamp_next;
                        count_next            = '0;
                        if (length_next == '0)
                        begin
                            result.status         = STATUS_OK;
                            result.end_of_message = 1'b1;
                            phase_next = item.buffer_end ? PH_HEADER : PH_SKIP;
                        end
                        else if (item.buffer_end)
                        begin
                            result.status         = STATUS_TRUNC;
                            result.payload_length = length_next;
                            result.end_of_message = 1'b1;
                            phase_next            = PH_HEADER;
                        end
                        else
                        begin
                            result.status         = STATUS_OK;
                            result.payload_length = length_next;
                            left_next             = length_next;
                            phase_next            = PH_PAYLOAD;
                        end
                    end
                    else if (item.buffer_end)
                    begin
                        res_valid             = 1'b1;
                        result.result_kind    = KIND_HEADER;
                        result.status         = STATUS_TRUNC;
                        result.end_of_message = 1'b1;
                        phase_next            = PH_HEADER;
                        count_next            = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 4'd1;
                    end
                end

                PH_PAYLOAD:
                begin
                    left_next             = left_dec;
                    res_valid             = 1'b1;
                    result.result_kind    = KIND_PAYLOAD;
                    result.message_type   = type_reg;
                    result.timestamp      = stamp_reg;
                    result.payload_length = length_reg;
                    result.payload_byte   = item.data_byte;
                    if (left_dec == '0)
                    begin
                        result.status         = STATUS_OK;
                        result.end_of_message = 1'b1;
                        phase_next = item.buffer_end ? PH_HEADER : PH_SKIP;
                        count_next = '0;
                    end
                    else if (item.buffer_end)
                    begin
                        result.status         = STATUS_TRUNC;
                        result.end_of_message = 1'b1;
                        phase_next            = PH_HEADER;
                        count_next            = '0;
                    end
                    else
                    begin
                        result.status = STATUS_OK;
                    end
                end

                default:
                begin
                    if (item.buffer_end)
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        stamp_reg  <= stamp_next;
        length_reg <= length_next;
        left_reg   <= left_next;
    end

endmodule

`default_nettype wire

[rtl/core/mfd_out_stage.sv]
// ----------------------------------------------------------------------------
// Message frame decoder output stage
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_out_stage
    import mfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    output logic         slot_ready,
    mfd_out_if.source    result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign slot_ready = !valid_reg || result_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign result_out.valid          = valid_reg;
    assign result_out.result_kind    = result_reg.result_kind;
    assign result_out.status         = result_reg.status;
    assign result_out.message_type   = result_reg.message_type;
    assign result_out.timestamp      = result_reg.timestamp;
    assign result_out.payload_length = result_reg.payload_length;
    assign result_out.payload_byte   = result_reg.payload_byte;
    assign result_out.end_of_message = result_reg.end_of_message;

endmodule

`default_nettype wire

[rtl/core/message_frame_decoder.sv]
// ----------------------------------------------------------------------------
// Message frame decoder
// Splits a byte stream into a 13-byte header result and payload results.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one buffer byte per transaction, buffer_end set on the
//   last byte of a buffer. result_out carries one header result after the
//   13th header byte, then one result per payload byte; end_of_message marks
//   the last result of a message and status flags a buffer that ended early.
//   Bytes past the payload give no result until buffer_end.
//   Path: a taken byte waits in the input register, then the frame state
//   update moves its result, if any, into the result register once free.
//   Throughput: one byte per cycle while result_out.ready stays high; the
//   frame state update is combinational between the two registers.
//   Reset: the decoder starts in the header phase with no pending
//   transaction on either side.
//   Stall: the result register holds its transaction while result_out.ready
//   is low; byte_in.ready drops once the input register also holds a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module message_frame_decoder
    import mfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mfd_in_if.sink    byte_in,
    mfd_out_if.source result_out
);

    item_t   item;
    logic    item_valid;
    logic    slot_ready;
    logic    advance;
    logic    res_valid;
    result_t result;

    assign advance = item_valid && slot_ready;

    mfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (advance)
    );

    mfd_frame_fsm u_frame_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .res_valid (res_valid),
        .result    (result)
    );

    mfd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && res_valid),
        .result     (result),
        .slot_ready (slot_ready),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

[rtl/core/mfd_checker.sv]
// ----------------------------------------------------------------------------
// Message frame decoder port checker
// Watches the result channel for message ordering and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "message_frame_decoder_defines.svh"

module mfd_checker
    import mfd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_kind,
    input wire logic        out_status,
    input wire logic [7:0]  out_type,
    input wire logic [63:0] out_stamp,
    input wire logic [31:0] out_length,
    input wire logic [7:0]  out_byte,
    input wire logic        out_eom
);

    logic         in_message_reg;
    logic         in_message_next;
    logic [114:0] out_fields;

    assign out_fields = {out_kind, out_status, out_type, out_stamp, out_length,
                         out_byte, out_eom};

    // open message: a header without end mark expects payload transactions
    always_comb
    begin
        in_message_next = in_message_reg;
        if (out_valid && out_ready)
        begin
            in_message_next = !out_eom;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
        end
        else
        begin
            in_message_reg <= in_message_next;
        end
    end

    `MFD_ASSERT_IMPLY(a_kind_order, clk, rst_n, out_valid, out_kind == in_message_reg)
    `MFD_ASSERT_IMPLY(a_trunc_ends, clk, rst_n, out_valid && out_status == STATUS_TRUNC, out_eom)
    `MFD_ASSERT_NEXT(a_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `MFD_ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && !out_ready, $stable(out_fields))

endmodule

bind message_frame_decoder mfd_checker u_mfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_kind   (result_out.result_kind),
    .out_status (result_out.status),
    .out_type   (result_out.message_type),
    .out_stamp  (result_out.timestamp),
    .out_length (result_out.payload_length),
    .out_byte   (result_out.payload_byte),
    .out_eom    (result_out.end_of_message)
);

`default_nettype wire
